// ===== src/ssied_pkg.sv =====
// ssied_pkg: types, constants and helpers for the SSI encoder frame decoder
// depends on nothing; used by the interfaces and every module in src

`default_nettype none

package ssied_pkg;

  // field and range limits
  localparam int unsigned MAX_FRAME_BITS    = 32;
  localparam int unsigned MAX_POSITION_BITS = 24;

  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned TAIL_W   = 31;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned ANGLE_W  = 12;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CLOCKS_W = 6;
  localparam int unsigned PBITS_W  = 5;
  localparam int unsigned TBITS_W  = 5;
  localparam int unsigned DISC_W   = 8;
  localparam int unsigned PROD_W   = 36;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CLOCKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BITS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_LINE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_COUNT = 3'd4;

  // register reset values
  localparam logic [CLOCKS_W-1:0] FRAME_CLOCKS_RST  = 6'd13;
  localparam logic [PBITS_W-1:0]  POSITION_BITS_RST = 5'd12;
  localparam logic [TBITS_W-1:0]  TAIL_BITS_RST     = 5'd1;
  localparam logic                INVERT_LINE_RST   = 1'b0;
  localparam logic [DISC_W-1:0]   DISCARD_COUNT_RST = 8'd0;

  // saturation limits in register widths
  localparam logic [CLOCKS_W-1:0] CLOCKS_MAX = CLOCKS_W'(MAX_FRAME_BITS);
  localparam logic [PBITS_W-1:0]  PBITS_MAX  = PBITS_W'(MAX_POSITION_BITS);

  // tenths of a degree per turn
  localparam logic [ANGLE_W-1:0] ANGLE_SCALE = 12'd3600;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [CLOCKS_W-1:0] frame_clocks;
    logic [PBITS_W-1:0]  position_bits;
    logic [TBITS_W-1:0]  tail_bits;
    logic                invert_line;
    logic [DISC_W-1:0]   discard_count;
    logic                discard_load;
  } ssied_cfg_t;

  // completed frame, between the front stage and the angle stage
  typedef struct packed {
    logic [FRAME_W-1:0] raw_frame;
    logic [TAIL_W-1:0]  tail_value;
    logic [POS_W-1:0]   gray_code;
    logic [POS_W-1:0]   position;
    logic [PBITS_W-1:0] pbits;
    logic               reading_valid;
    logic [COUNT_W-1:0] reading_count;
  } ssied_frame_t;

  // gray to binary by prefix xor, five doubling steps cover 24 bits
  function automatic logic [POS_W-1:0] gray_to_bin(input logic [POS_W-1:0] g);
    logic [POS_W-1:0] b;
    b = g;
    b = b ^ (b >> 1);
    b = b ^ (b >> 2);
    b = b ^ (b >> 4);
    b = b ^ (b >> 8);
    b = b ^ (b >> 16);
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/ssied_ifs.sv =====
// ssied_ifs: valid/ready channel interfaces for bits in, readings out and config writes
// depends on ssied_pkg

`default_nettype none

// one sampled data bit per beat
interface ssied_bit_if;
  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, output data_bit, input ready);
  modport sink   (input valid, input data_bit, output ready);
endinterface

// one decoded reading per beat
interface ssied_rd_if;
  import ssied_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] raw_frame;
  logic [TAIL_W-1:0]  tail_value;
  logic [POS_W-1:0]   gray_code;
  logic [POS_W-1:0]   position;
  logic [ANGLE_W-1:0] angle_tenths;
  logic               reading_valid;
  logic [COUNT_W-1:0] reading_count;

  modport source (output valid, output raw_frame, output tail_value, output gray_code,
                  output position, output angle_tenths, output reading_valid,
                  output reading_count, input ready);
  modport sink   (input valid, input raw_frame, input tail_value, input gray_code,
                  input position, input angle_tenths, input reading_valid,
                  input reading_count, output ready);
endinterface

// register write per beat
interface ssied_cfg_if;
  import ssied_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== src/ssied_cfg_regs.sv =====
// ssied_cfg_regs: configuration register file with write decode
// depends on ssied_pkg and ssied_ifs

`default_nettype none

module ssied_cfg_regs (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  ssied_cfg_if.sink              cfg_i,
  output ssied_pkg::ssied_cfg_t  cfg_o
);
  import ssied_pkg::*;

  logic [CLOCKS_W-1:0] frame_clocks_q;
  logic [PBITS_W-1:0]  position_bits_q;
  logic [TBITS_W-1:0]  tail_bits_q;
  logic                invert_line_q;
  logic                wr;
  logic                disc_wr;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;
  assign disc_wr     = wr && (cfg_i.reg_index == REG_DISCARD_COUNT);

  // register write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_clocks_q  <= FRAME_CLOCKS_RST;
      position_bits_q <= POSITION_BITS_RST;
      tail_bits_q     <= TAIL_BITS_RST;
      invert_line_q   <= INVERT_LINE_RST;
    end else if (wr) begin
      unique case (cfg_i.reg_index)
        REG_FRAME_CLOCKS:  frame_clocks_q  <= cfg_i.wdata[CLOCKS_W-1:0];
        REG_POSITION_BITS: position_bits_q <= cfg_i.wdata[PBITS_W-1:0];
        REG_TAIL_BITS:     tail_bits_q     <= cfg_i.wdata[TBITS_W-1:0];
        REG_INVERT_LINE:   invert_line_q   <= cfg_i.wdata[0];
        // the discard count only loads the discard counter, see discard_load
        REG_DISCARD_COUNT: ;
        default: ;
      endcase
    end
  end

  // discard_load carries the new count straight to the discard counter
  always_comb begin
    cfg_o.frame_clocks  = frame_clocks_q;
    cfg_o.position_bits = position_bits_q;
    cfg_o.tail_bits     = tail_bits_q;
    cfg_o.invert_line   = invert_line_q;
    cfg_o.discard_count = cfg_i.wdata[DISC_W-1:0];
    cfg_o.discard_load  = disc_wr;
  end

endmodule

`default_nettype wire

// ===== src/ssied_frame_front.sv =====
// ssied_frame_front: bit shifter, frame counter, discard and read counters, gray decode
// depends on ssied_pkg and ssied_ifs

`default_nettype none

module ssied_frame_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  ssied_bit_if.sink               bit_i,
  input  ssied_pkg::ssied_cfg_t   cfg_i,
  output logic                    frm_valid_o,
  input  wire                     frm_ready_i,
  output ssied_pkg::ssied_frame_t frm_o
);
  import ssied_pkg::*;

  logic [FRAME_W-1:0]  shift_q, shift_d, shift_n;
  logic [CLOCKS_W-1:0] cnt_q, cnt_d, cnt_n;
  logic [DISC_W-1:0]   disc_q, disc_d;
  logic [COUNT_W-1:0]  total_q, total_d;
  logic                frm_vq;
  ssied_frame_t        frm_q, frm_d;

  logic                acc, done, bit_in;
  logic [CLOCKS_W-1:0] clocks;
  logic [PBITS_W-1:0]  pbits;
  logic [FRAME_W-1:0]  raw, frame_mask, above_tail;
  logic [FRAME_W-1:0]  tail_mask;
  logic [POS_W-1:0]    pos_mask, gray;

  assign bit_i.ready = !frm_vq || frm_ready_i;
  assign acc         = bit_i.valid && bit_i.ready;

  // saturate frame length and field width
  always_comb begin
    if (cfg_i.frame_clocks == '0) begin
      clocks = CLOCKS_W'(1);
    end else if (cfg_i.frame_clocks > CLOCKS_MAX) begin
      clocks = CLOCKS_MAX;
    end else begin
      clocks = cfg_i.frame_clocks;
    end
    if (cfg_i.position_bits > PBITS_MAX) begin
      pbits = PBITS_MAX;
    end else begin
      pbits = cfg_i.position_bits;
    end
  end

  // shift and count one beat
  assign bit_in  = bit_i.data_bit ^ cfg_i.invert_line;
  assign shift_n = {shift_q[FRAME_W-2:0], bit_in};
  assign cnt_n   = cnt_q + CLOCKS_W'(1);
  assign done    = cnt_n >= clocks;

  // field extraction of the finished frame
  assign frame_mask = ~({FRAME_W{1'b1}} << clocks);
  assign raw        = shift_n & frame_mask;
  assign tail_mask  = ~({FRAME_W{1'b1}} << cfg_i.tail_bits);
  assign above_tail = raw >> cfg_i.tail_bits;
  assign pos_mask   = ~({POS_W{1'b1}} << pbits);
  assign gray       = above_tail[POS_W-1:0] & pos_mask;

  // next state of the frame, discard and read counters
  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    disc_d  = disc_q;
    total_d = total_q;
    if (acc) begin
      if (done) begin
        shift_d = '0;
        cnt_d   = '0;
        if (disc_q != '0) begin
          disc_d = disc_q - DISC_W'(1);
        end else begin
          total_d = total_q + COUNT_W'(1);
        end
      end else begin
        shift_d = shift_n;
        cnt_d   = cnt_n;
      end
    end
    if (cfg_i.discard_load) begin
      disc_d = cfg_i.discard_count;
    end
  end

  // payload of the frame register
  always_comb begin
    frm_d.raw_frame     = raw;
    frm_d.tail_value    = TAIL_W'(raw & tail_mask);
    frm_d.gray_code     = gray;
    frm_d.position      = gray_to_bin(gray);
    frm_d.pbits         = pbits;
    frm_d.reading_valid = (disc_q == '0);
    frm_d.reading_count = total_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      cnt_q   <= '0;
      disc_q  <= DISCARD_COUNT_RST;
      total_q <= '0;
      frm_vq  <= 1'b0;
    end else begin
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
      total_q <= total_d;
      if (acc && done) begin
        frm_vq <= 1'b1;
      end else if (frm_ready_i) begin
        frm_vq <= 1'b0;
      end
    end
  end

  // frame payload register
  always_ff @(posedge clk_i) begin
    if (acc && done) begin
      frm_q <= frm_d;
    end
  end

  assign frm_valid_o = frm_vq;
  assign frm_o       = frm_q;

endmodule

`default_nettype wire

// ===== src/ssied_angle_out.sv =====
// ssied_angle_out: angle scaling and rounding into the output register
// depends on ssied_pkg and ssied_ifs

`default_nettype none

module ssied_angle_out (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     frm_valid_i,
  output logic                    frm_ready_o,
  input  ssied_pkg::ssied_frame_t frm_i,
  ssied_rd_if.source              rd_o
);
  import ssied_pkg::*;

  logic               out_vq;
  logic               load;
  logic [PROD_W-1:0]  prod, half, sum, scaled;
  logic [ANGLE_W-1:0] angle;

  logic [FRAME_W-1:0] raw_q;
  logic [TAIL_W-1:0]  tail_q;
  logic [POS_W-1:0]   gray_q, pos_q;
  logic [ANGLE_W-1:0] angle_q;
  logic               rvalid_q;
  logic [COUNT_W-1:0] count_q;

  assign frm_ready_o = !out_vq || rd_o.ready;
  assign load        = frm_valid_i && frm_ready_o;

  // angle = (pos * 3600 + half lsb) >> width, zero for an empty field
  assign prod   = PROD_W'(frm_i.position) * PROD_W'(ANGLE_SCALE);
  assign half   = PROD_W'(1) << (frm_i.pbits - PBITS_W'(1));
  assign sum    = prod + half;
  assign scaled = sum >> frm_i.pbits;
  assign angle  = (frm_i.pbits == '0) ? '0 : scaled[ANGLE_W-1:0];

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (load) begin
      out_vq <= 1'b1;
    end else if (rd_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      raw_q    <= frm_i.raw_frame;
      tail_q   <= frm_i.tail_value;
      gray_q   <= frm_i.gray_code;
      pos_q    <= frm_i.position;
      angle_q  <= angle;
      rvalid_q <= frm_i.reading_valid;
      count_q  <= frm_i.reading_count;
    end
  end

  assign rd_o.valid         = out_vq;
  assign rd_o.raw_frame     = raw_q;
  assign rd_o.tail_value    = tail_q;
  assign rd_o.gray_code     = gray_q;
  assign rd_o.position      = pos_q;
  assign rd_o.angle_tenths  = angle_q;
  assign rd_o.reading_valid = rvalid_q;
  assign rd_o.reading_count = count_q;

endmodule

`default_nettype wire

// ===== src/ssi_encoder_frame_decoder.sv =====
// ssi_encoder_frame_decoder: top level of the SSI absolute encoder frame decoder
// depends on ssied_pkg, ssied_ifs, ssied_cfg_regs, ssied_frame_front, ssied_angle_out
//
//  channel  dir  beat
//  -------  ---  ---------------------------------------------------------------
//  bit_i    in   one sampled data bit
//  rd_o     out  one decoded reading per completed frame
//  cfg_i    in   register write: reg_index, wdata (always ready)
//
// one data bit is taken per cycle; a completed frame passes through the frame register
// and then the angle output register on its way to rd_o.
// bit_i stalls only while both registers hold readings and rd_o is not ready.
// reset clears the frame, counters and valids; registers return to defaults.

`default_nettype none

module ssi_encoder_frame_decoder (
  input  wire        clk_i,
  input  wire        rst_ni,
  ssied_bit_if.sink  bit_i,
  ssied_cfg_if.sink  cfg_i,
  ssied_rd_if.source rd_o
);
  import ssied_pkg::*;

  ssied_cfg_t   cfg;
  ssied_frame_t frm;
  logic         frm_valid;
  logic         frm_ready;

  // configuration registers
  ssied_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // shift, count and decode
  ssied_frame_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bit_i       (bit_i),
    .cfg_i       (cfg),
    .frm_valid_o (frm_valid),
    .frm_ready_i (frm_ready),
    .frm_o       (frm)
  );

  // angle and output register
  ssied_angle_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (frm_valid),
    .frm_ready_o (frm_ready),
    .frm_i       (frm),
    .rd_o        (rd_o)
  );

endmodule

`default_nettype wire

// ===== dv/ssied_reading_checker.sv =====
`timescale 1ns / 1ps
// ssied_reading_checker: watches the bit, register and reading channels of the decoder,
// keeps its own copy of the decode state and compares every reading field by field
// depends on ssied_pkg and ssied_ifs

module ssied_reading_checker
  import ssied_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  ssied_bit_if        bit_i,
  ssied_cfg_if        cfg_i,
  ssied_rd_if         rd_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [FRAME_W-1:0] raw_frame;
    logic [TAIL_W-1:0]  tail_value;
    logic [POS_W-1:0]   gray_code;
    logic [POS_W-1:0]   position;
    logic [ANGLE_W-1:0] angle_tenths;
    logic               reading_valid;
    logic [COUNT_W-1:0] reading_count;
  } reading_t;

  // shadow registers
  logic [CLOCKS_W-1:0] frame_clocks_q;
  logic [PBITS_W-1:0]  position_bits_q;
  logic [TBITS_W-1:0]  tail_bits_q;
  logic                invert_q;

  // shadow decode state
  logic [FRAME_W-1:0]  shift_q;
  logic [CLOCKS_W-1:0] bits_q;
  logic [DISC_W-1:0]   discard_left_q;
  logic [COUNT_W-1:0]  valid_total_q;

  reading_t readings_due[$];
  reading_t want;

  function automatic logic [63:0] ones_below(input int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // binary from gray, msb down
  function automatic logic [POS_W-1:0] gray_decode(input logic [POS_W-1:0] g);
    logic [POS_W-1:0] b;
    b[POS_W-1] = g[POS_W-1];
    for (int i = POS_W - 2; i >= 0; i--) b[i] = b[i+1] ^ g[i];
    return b;
  endfunction

  // shift one line bit in; a full frame queues the reading it decodes to
  task automatic take_bit(input logic line_bit);
    int unsigned clocks;
    int unsigned pbits;
    logic [63:0] frame;
    logic [63:0] scaled;
    reading_t r;
    clocks = frame_clocks_q;
    if (clocks < 1) clocks = 1;
    if (clocks > MAX_FRAME_BITS) clocks = MAX_FRAME_BITS;
    pbits = position_bits_q;
    if (pbits > MAX_POSITION_BITS) pbits = MAX_POSITION_BITS;

    shift_q = {shift_q[FRAME_W-2:0], line_bit ^ invert_q};
    bits_q  = bits_q + 1'b1;
    if (bits_q < clocks) return;

    frame   = {32'd0, shift_q} & ones_below(clocks);
    shift_q = '0;
    bits_q  = '0;

    r = '0;
    r.raw_frame  = frame[FRAME_W-1:0];
    r.tail_value = TAIL_W'(frame & ones_below(tail_bits_q));
    // empty position field leaves gray, position and angle at zero
    if (pbits != 0) begin
      r.gray_code    = POS_W'((frame >> tail_bits_q) & ones_below(pbits));
      r.position     = gray_decode(r.gray_code);
      scaled         = 64'(r.position) * 64'(ANGLE_SCALE) + (64'd1 << (pbits - 1));
      r.angle_tenths = ANGLE_W'(scaled >> pbits);
    end

    // startup discard
    if (discard_left_q != 0) begin
      discard_left_q  = discard_left_q - 1'b1;
      r.reading_valid = 1'b0;
    end else begin
      r.reading_valid = 1'b1;
      valid_total_q   = valid_total_q + 1'b1;
    end
    r.reading_count = valid_total_q;
    readings_due.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      fail_count_o++;
      if (fail_count_o <= REPORT_LIMIT)
        $display("reading %0d %s: expected %h, got %h", checked_o, field, exp_val, got_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_clocks_q  = FRAME_CLOCKS_RST;
      position_bits_q = POSITION_BITS_RST;
      tail_bits_q     = TAIL_BITS_RST;
      invert_q        = INVERT_LINE_RST;
      shift_q         = '0;
      bits_q          = '0;
      discard_left_q  = DISCARD_COUNT_RST;
      valid_total_q   = '0;
      readings_due.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      checked_o       = 0;
    end else begin
      // register write beat
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.reg_index)
          REG_FRAME_CLOCKS:  frame_clocks_q  = cfg_i.wdata[CLOCKS_W-1:0];
          REG_POSITION_BITS: position_bits_q = cfg_i.wdata[PBITS_W-1:0];
          REG_TAIL_BITS:     tail_bits_q     = cfg_i.wdata[TBITS_W-1:0];
          REG_INVERT_LINE:   invert_q        = cfg_i.wdata[0];
          REG_DISCARD_COUNT: discard_left_q  = cfg_i.wdata[DISC_W-1:0];
          default: ;
        endcase
      end

      // data bit beat
      if (bit_i.valid && bit_i.ready) take_bit(bit_i.data_bit);

      // reading beat
      if (rd_i.valid && rd_i.ready) begin
        if (readings_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("reading with none expected: raw frame %h", rd_i.raw_frame);
        end else begin
          want = readings_due.pop_front();
          check_field("raw_frame", want.raw_frame, rd_i.raw_frame);
          check_field("tail_value", want.tail_value, rd_i.tail_value);
          check_field("gray_code", want.gray_code, rd_i.gray_code);
          check_field("position", want.position, rd_i.position);
          check_field("angle_tenths", want.angle_tenths, rd_i.angle_tenths);
          check_field("reading_valid", want.reading_valid, rd_i.reading_valid);
          check_field("reading_count", want.reading_count, rd_i.reading_count);
          checked_o++;
        end
      end
      pending_o = readings_due.size();
    end
  end

endmodule

// ===== dv/ssi_encoder_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// ssi_encoder_frame_decoder_tb: drives data bits and register writes into the decoder
// and gives the verdict; depends on ssied_pkg, ssied_ifs, the decoder and its checker

module ssi_encoder_frame_decoder_tb;
  import ssied_pkg::*;

  localparam int unsigned TOTAL_BITS   = 950;
  localparam int unsigned IDLE_PCT     = 19;
  localparam int unsigned CALM_FROM    = 300;
  localparam int unsigned CALM_TO      = 460;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RESET_CYCLES = 7;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_DISCARD_COUNT + 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        calm;
  int unsigned bits_sent;
  int unsigned settings;
  int unsigned frame_len;
  int unsigned cycles;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  ssied_bit_if bit_ch ();
  ssied_cfg_if cfg_ch ();
  ssied_rd_if  rd_ch ();

  ssi_encoder_frame_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bit_i  (bit_ch),
    .cfg_i  (cfg_ch),
    .rd_o   (rd_ch)
  );

  ssied_reading_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bit_i        (bit_ch),
    .cfg_i        (cfg_ch),
    .rd_i         (rd_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d readings outstanding", cycles, pending);
      $display("ssi_encoder_frame_decoder: mismatch");
      $finish;
    end
  end

  // stretch without idling on either side
  always @(posedge clk_i) calm <= (bits_sent >= CALM_FROM) && (bits_sent < CALM_TO);

  // reading sink backpressure
  always @(negedge clk_i) rd_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic send_bit(input logic b);
    while (!calm && chance(IDLE_PCT)) begin
      bit_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    bit_ch.valid    <= 1'b1;
    bit_ch.data_bit <= b;
    do @(posedge clk_i); while (!bit_ch.ready);
    @(negedge clk_i);
    bits_sent++;
  endtask

  // low n bits of pattern, first bit most significant
  task automatic send_pattern(input logic [31:0] pattern, input int n);
    for (int i = n - 1; i >= 0; i--) send_bit(pattern[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int unsigned len;
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
    // effective frame length for sizing later beats
    if (idx == REG_FRAME_CLOCKS) begin
      len = data[CLOCKS_W-1:0];
      if (len < 1) len = 1;
      if (len > MAX_FRAME_BITS) len = MAX_FRAME_BITS;
      frame_len = len;
    end
  endtask

  // stop bits, let every reading drain, then wait out the pipeline
  task automatic settle();
    bit_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic reconfigure(input bit every);
    int unsigned pick;
    logic [CFG_DATA_W-1:0] v;
    settings++;
    if (every || chance(40)) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       v = CFG_DATA_W'($urandom_range(1, 16));
      else if (pick == 6) v = CFG_DATA_W'(MAX_FRAME_BITS);
      else if (pick == 7) v = CFG_DATA_W'($urandom_range(17, 31));
      else                v = CFG_DATA_W'($urandom_range(0, 255));
      write_reg(REG_FRAME_CLOCKS, v);
    end
    if (every || chance(40)) begin
      if (chance(70)) v = CFG_DATA_W'($urandom_range(0, MAX_POSITION_BITS));
      else            v = CFG_DATA_W'($urandom_range(0, 255));
      write_reg(REG_POSITION_BITS, v);
    end
    if (every || chance(40)) begin
      if (chance(70)) v = CFG_DATA_W'($urandom_range(0, 4));
      else            v = CFG_DATA_W'($urandom_range(0, 255));
      write_reg(REG_TAIL_BITS, v);
    end
    if (every || chance(40)) write_reg(REG_INVERT_LINE, CFG_DATA_W'($urandom_range(0, 255)));
    if (every || chance(40)) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)       v = '0;
      else if (pick < 18)  v = CFG_DATA_W'($urandom_range(1, 3));
      else if (pick == 18) v = '1;
      else                 v = CFG_DATA_W'($urandom_range(0, 255));
      write_reg(REG_DISCARD_COUNT, v);
    end
    // writes to unused indexes must change nothing
    if (chance(8))
      write_reg(CFG_IDX_W'(REG_FIRST_UNUSED + $urandom_range(0, 2)),
                CFG_DATA_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned frames;
    rst_ni           = 1'b0;
    calm             = 1'b0;
    bit_ch.valid     = 1'b0;
    bit_ch.data_bit  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_FRAME_CLOCKS;
    cfg_ch.wdata     = '0;
    rd_ch.ready      = 1'b0;
    frame_len        = FRAME_CLOCKS_RST;
    settings         = 1;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, all ones fills the whole gray field
    send_pattern(32'h1FFF, 13);
    settle();

    // zero frame length saturates to one bit, empty position field
    write_reg(REG_FRAME_CLOCKS, 8'h00);
    write_reg(REG_POSITION_BITS, 8'h00);
    settings++;
    send_pattern(32'h1, 1);
    send_pattern(32'h0, 1);
    settle();

    // upper register bits dropped, oversized position width, inverted line, one discard
    write_reg(REG_FRAME_CLOCKS, 8'h45);
    write_reg(REG_POSITION_BITS, 8'h1F);
    write_reg(REG_TAIL_BITS, 8'h00);
    write_reg(REG_INVERT_LINE, 8'hFF);
    write_reg(REG_DISCARD_COUNT, 8'h01);
    settings++;
    send_pattern(32'h16, 5);
    send_pattern(32'h09, 5);
    settle();

    // frame length lowered below the bits already taken
    write_reg(REG_FRAME_CLOCKS, 8'h08);
    write_reg(REG_INVERT_LINE, 8'h00);
    settings++;
    send_pattern(32'h1A, 5);
    settle();
    write_reg(REG_FRAME_CLOCKS, 8'h03);
    settings++;
    send_pattern(32'h1, 1);
    settle();
    write_reg(REG_DISCARD_COUNT, 8'hFF);

    // random settings, whole frames of random bits, sometimes a partial frame left over
    reconfigure(1'b1);
    while (bits_sent < TOTAL_BITS) begin
      frames = $urandom_range(1, 4);
      repeat (frames) send_pattern($urandom, frame_len);
      if (frame_len > 1 && chance(35)) send_pattern($urandom, $urandom_range(1, frame_len - 1));
      settle();
      reconfigure(1'b0);
    end

    settle();
    $display("sent %0d data bits under %0d register settings, compared %0d readings",
             bits_sent, settings, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ssi_encoder_frame_decoder: match");
    end else begin
      $display("ssi_encoder_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ssied_pkg.sv
src/ssied_ifs.sv
src/ssied_cfg_regs.sv
src/ssied_frame_front.sv
src/ssied_angle_out.sv
src/ssi_encoder_frame_decoder.sv
dv/ssied_reading_checker.sv
dv/ssi_encoder_frame_decoder_tb.sv
